// ----- rtl/dwrs_pkg.sv -----
`default_nettype none
package dwrs_pkg;

	localparam int unsigned PANEL_WIDTH  = 176;
	localparam int unsigned PANEL_HEIGHT = 220;

	// Panel coordinates never exceed 219, so eight bits hold them.
	localparam int unsigned COORD_W = 8;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [1:0]         rotation_t;
	typedef logic [2:0]         scan_mode_t;

	// One classified window, as handed from the front to the back.
	typedef struct packed {
		scan_mode_t mode;
		coord_t     lo_x;
		coord_t     hi_x;
		coord_t     lo_y;
		coord_t     hi_y;
	} window_t;

	// Queue handshake between front and back.
	typedef struct packed {
		logic    push;
		window_t entry;
	} push_req_t;

	typedef struct packed {
		logic    valid;
		window_t head;
	} head_t;

	typedef enum logic [7:0] {
		REG_ADDR_COL   = 8'h20,
		REG_ADDR_ROW   = 8'h21,
		REG_PIXEL_DATA = 8'h22,
		REG_ENTRY      = 8'h03,
		REG_HEND       = 8'h36,
		REG_HSTART     = 8'h37,
		REG_VEND       = 8'h38,
		REG_VSTART     = 8'h39
	} reg_code_t;

	localparam logic [15:0] ENTRY_BASE = 16'h1000;

	function automatic scan_mode_t scan_mode_of(rotation_t rot);
		scan_mode_t m;
		case (rot)
			2'd0:    m = 3'd6;
			2'd1:    m = 3'd5;
			2'd2:    m = 3'd0;
			2'd3:    m = 3'd3;
			default: m = 3'd6;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/dwrs_win_if.sv -----
`default_nettype none
interface dwrs_win_if;
	logic        valid;
	logic        ready;
	logic [15:0] corner_a_x;
	logic [15:0] corner_a_y;
	logic [15:0] corner_b_x;
	logic [15:0] corner_b_y;

	modport source (output valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
		input ready);
	modport sink (input valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
		output ready);
endinterface
`default_nettype wire

// ----- rtl/dwrs_reg_if.sv -----
`default_nettype none
interface dwrs_reg_if;
	logic        valid;
	logic        ready;
	logic        command_only;
	logic [7:0]  register_index;
	logic [15:0] write_data;
	logic        final_item;

	modport source (output valid, command_only, register_index, write_data, final_item,
		input ready);
	modport sink (input valid, command_only, register_index, write_data, final_item,
		output ready);
endinterface
`default_nettype wire

// ----- rtl/dwrs_cfg_if.sv -----
`default_nettype none
interface dwrs_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/dwrs_front.sv -----
`default_nettype none
module dwrs_front import dwrs_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	dwrs_win_if.sink    window,
	dwrs_cfg_if.sink    cfg,
	input  wire         queue_full,
	output push_req_t   push_req
);

	rotation_t rotation_q;
	window_t   win_s1;
	logic      valid_s1;

	logic      swapped;
	coord_t    w_max;
	coord_t    h_max;
	coord_t    ax, ay, bx, by;
	window_t   win_next;
	logic      accept;
	logic      push;

	function automatic coord_t clip(logic [15:0] v, coord_t lim);
		return (v > {{(16-COORD_W){1'b0}}, lim}) ? lim : v[COORD_W-1:0];
	endfunction

	// Map a clipped logical corner onto panel coordinates.
	function automatic logic [2*COORD_W-1:0] map_corner(rotation_t rot, coord_t cx,
		coord_t cy, coord_t wm, coord_t hm);
		coord_t px;
		coord_t py;
		case (rot)
			2'd1: begin
				px = hm - cy;
				py = cx;
			end
			2'd2: begin
				px = wm - cx;
				py = hm - cy;
			end
			2'd3: begin
				px = cy;
				py = wm - cx;
			end
			default: begin
				px = cx;
				py = cy;
			end
		endcase
		return {px, py};
	endfunction

	assign cfg.ready = 1'b1;

	assign swapped = rotation_q[0];
	assign w_max   = swapped ? COORD_W'(PANEL_HEIGHT - 1) : COORD_W'(PANEL_WIDTH - 1);
	assign h_max   = swapped ? COORD_W'(PANEL_WIDTH - 1) : COORD_W'(PANEL_HEIGHT - 1);

	always_comb begin
		{ax, ay} = map_corner(rotation_q, clip(window.corner_a_x, w_max),
			clip(window.corner_a_y, h_max), w_max, h_max);
		{bx, by} = map_corner(rotation_q, clip(window.corner_b_x, w_max),
			clip(window.corner_b_y, h_max), w_max, h_max);
		win_next.mode = scan_mode_of(rotation_q);
		win_next.lo_x = (bx < ax) ? bx : ax;
		win_next.hi_x = (bx < ax) ? ax : bx;
		win_next.lo_y = (by < ay) ? by : ay;
		win_next.hi_y = (by < ay) ? ay : by;
	end

	assign push         = valid_s1 && !queue_full;
	assign window.ready = !valid_s1 || !queue_full;
	assign accept       = window.valid && window.ready;

	assign push_req.push  = push;
	assign push_req.entry = win_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				rotation_q <= cfg.data;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_s1 <= win_next;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/dwrs_queue.sv -----
`default_nettype none
module dwrs_queue import dwrs_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  push_req_t  push_req,
	input  wire        pop,
	output logic       full,
	output head_t      head
);

	window_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_pop;

	assign full       = (count_q == 2'd2);
	assign head.valid = (count_q != 2'd0);
	assign head.head  = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_req.push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push_req.push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_req.push) begin
			mem_q[wr_ptr_q] <= push_req.entry;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/dwrs_back.sv -----
`default_nettype none
module dwrs_back import dwrs_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  head_t       head,
	output logic        pop,
	dwrs_reg_if.source  reg_item
);

	typedef enum logic [2:0] {
		STEP_ENTRY,
		STEP_HEND,
		STEP_HSTART,
		STEP_VEND,
		STEP_VSTART,
		STEP_ADDR_COL,
		STEP_ADDR_ROW,
		STEP_PIXEL
	} step_t;

	step_t       step_q;
	logic        out_valid_q;
	logic        cmd_only_q;
	logic [7:0]  reg_index_q;
	logic [15:0] data_q;
	logic        final_q;

	logic        advance;
	coord_t      start_x;
	coord_t      start_y;
	logic        n_cmd_only;
	reg_code_t   n_reg;
	logic [15:0] n_data;

	assign advance = head.valid && (!out_valid_q || reg_item.ready);
	assign pop     = advance && (step_q == STEP_PIXEL);

	always_comb begin
		case (head.head.mode[2:1])
			2'd0: begin
				start_x = head.head.hi_x;
				start_y = head.head.hi_y;
			end
			2'd1: begin
				start_x = head.head.lo_x;
				start_y = head.head.hi_y;
			end
			2'd2: begin
				start_x = head.head.hi_x;
				start_y = head.head.lo_y;
			end
			default: begin
				start_x = head.head.lo_x;
				start_y = head.head.lo_y;
			end
		endcase
	end

	always_comb begin
		n_cmd_only = 1'b0;
		n_data     = '0;
		case (step_q)
			STEP_ENTRY: begin
				n_reg  = REG_ENTRY;
				n_data = ENTRY_BASE | {10'd0, head.head.mode, 3'd0};
			end
			STEP_HEND: begin
				n_reg  = REG_HEND;
				n_data = 16'(head.head.hi_x);
			end
			STEP_HSTART: begin
				n_reg  = REG_HSTART;
				n_data = 16'(head.head.lo_x);
			end
			STEP_VEND: begin
				n_reg  = REG_VEND;
				n_data = 16'(head.head.hi_y);
			end
			STEP_VSTART: begin
				n_reg  = REG_VSTART;
				n_data = 16'(head.head.lo_y);
			end
			STEP_ADDR_COL: begin
				n_reg  = REG_ADDR_COL;
				n_data = 16'(start_x);
			end
			STEP_ADDR_ROW: begin
				n_reg  = REG_ADDR_ROW;
				n_data = 16'(start_y);
			end
			default: begin
				n_reg      = REG_PIXEL_DATA;
				n_cmd_only = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_ENTRY;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				step_q      <= step_t'(step_q + 3'd1);
				out_valid_q <= 1'b1;
			end else if (reg_item.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_only_q  <= n_cmd_only;
			reg_index_q <= n_reg;
			data_q      <= n_data;
			final_q     <= (step_q == STEP_PIXEL);
		end
	end

	assign reg_item.valid          = out_valid_q;
	assign reg_item.command_only   = cmd_only_q;
	assign reg_item.register_index = reg_index_q;
	assign reg_item.write_data     = data_q;
	assign reg_item.final_item     = final_q;

endmodule
`default_nettype wire

// ----- rtl/display_window_register_setup.sv -----
`default_nettype none
// Channel    Dir   Payload                                      Transfer
// window     in    corner_a_x/_y, corner_b_x/_y (16 b each)     valid & ready
// reg_item   out   command_only, register_index, write_data,    valid & ready
//                  final_item
// cfg        in    data: rotation (2 b)                         valid & ready
//
// Each window yields eight register items, one per cycle while reg_item is not
// stalled; the back sequencer steps through them and pops the window with its
// last item. An item passes the front stage, the queue and the output register.
// Reset clears rotation to 0, the front stage, the queue and the sequencer.
// A stall on reg_item holds the output register; the two-entry queue and the
// front stage keep taking windows until both are full.
module display_window_register_setup import dwrs_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	dwrs_win_if.sink    window,
	dwrs_cfg_if.sink    cfg,
	dwrs_reg_if.source  reg_item
);

	push_req_t push_req;
	head_t     head;
	logic      queue_full;
	logic      pop;

	// Clip, map and sort the corners; hold the rotation register.
	dwrs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.window     (window),
		.cfg        (cfg),
		.queue_full (queue_full),
		.push_req   (push_req)
	);

	// Decouple classification from item issue.
	dwrs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_req (push_req),
		.pop      (pop),
		.full     (queue_full),
		.head     (head)
	);

	// Step through the eight register items of the head window.
	dwrs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.reg_item (reg_item)
	);

endmodule
`default_nettype wire
